>>> sv/hbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbe_pkg: shared types and constants for the histogram binning engine
// Item formats, operation codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package hbe_pkg;

    // Bin store geometry; the read_index field takes its width from the address width
    localparam int BIN_AW    = 10;
    localparam int BINS      = 1 << BIN_AW;
    localparam int BIN_WIDTH = 48;
    localparam int COUNT_W   = 40;
    localparam int NBINS_W   = BIN_AW + 1;

    localparam logic [NBINS_W-1:0] BINS_IN_USE_RST = NBINS_W'(BINS);
    localparam logic [31:0]        BIN_SCALE_RST   = 32'd65536;

    // Operation codes
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RANGE_LOW   = 2'd0,
        CFG_BIN_SCALE   = 2'd1,
        CFG_BINS_IN_USE = 2'd2,
        CFG_WEIGHTED    = 2'd3
    } cfg_idx_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOOK,
        ST_RMW,
        ST_CLEAR,
        ST_CEMIT
    } state_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] sample;
        logic signed [31:0] weight;
        logic [BIN_AW-1:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic signed [BIN_WIDTH-1:0] bin_value;
        logic [COUNT_W-1:0]          binned_total;
        logic                        accepted;
        logic [BIN_AW-1:0]           sample_bin;
    } out_item_t;

endpackage

>>> sv/histogram_binning_engine_unit.sv
`timescale 1ns / 1ps
// Result path: a sample, read or unused operation passes the multiply, lookup and update states;
// an output stall holds it in the update state. Input is stalled until the item leaves it,
// as the registered multiply and registered bin memory read come before the read-modify-write.
// Clear: the result follows a sweep over all 1024 bins, one bin per cycle, with input stalled.
// Reset: the same sweep runs after reset; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
// histogram_binning_engine_unit
// Uniform-bin histogram: bins a Q16.16 sample by (sample - low) * scale into a
// 1024 x 48 bin memory with saturating add, counts binned samples, reads bins.
// ----------------------------------------------------------------------------
module histogram_binning_engine_unit
    import hbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic signed [BIN_WIDTH:0] BIN_MAX = {2'b00, {(BIN_WIDTH-1){1'b1}}};
    localparam logic signed [BIN_WIDTH:0] BIN_MIN = {2'b11, {(BIN_WIDTH-1){1'b0}}};
    localparam logic [COUNT_W-1:0]        COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration registers
    logic signed [31:0]   range_low_reg;
    logic [31:0]          bin_scale_reg;
    logic [NBINS_W-1:0]   bins_in_use_reg;
    logic                 weighted_reg;

    // Controller and item registers
    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic signed [32:0]   diff_reg;
    logic signed [31:0]   weight_reg;
    logic [BIN_AW-1:0]    rd_idx_reg;
    logic [63:0]          prod_reg;
    logic [BIN_AW-1:0]    addr_reg;
    logic                 hit_reg;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [BIN_AW-1:0]    clr_ptr_reg;
    logic                 clear_emit_reg;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    // Bin memory
    logic [BIN_WIDTH-1:0] bin_mem [BINS];
    logic [BIN_WIDTH-1:0] rdata_reg;
    logic                 mem_re;
    logic [BIN_AW-1:0]    mem_raddr;
    logic                 mem_we;
    logic [BIN_AW-1:0]    mem_waddr;
    logic [BIN_WIDTH-1:0] mem_wdata;

    // Datapath signals
    logic                 in_xfer;
    logic                 out_free;
    logic                 load_out;
    out_item_t            out_load;
    logic [31:0]          look_idx;
    logic [NBINS_W-1:0]   n_used;
    logic                 look_hit;
    logic signed [BIN_WIDTH:0] bin_inc;
    logic signed [BIN_WIDTH:0] bin_sum;
    logic signed [BIN_WIDTH-1:0] bin_new;
    logic [COUNT_W-1:0]   count_inc;
    logic                 clr_last;

    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign clr_last  = (clr_ptr_reg == BIN_AW'(BINS - 1));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg   <= '0;
            bin_scale_reg   <= BIN_SCALE_RST;
            bins_in_use_reg <= BINS_IN_USE_RST;
            weighted_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RANGE_LOW:   range_low_reg   <= cfg_data;
                CFG_BIN_SCALE:   bin_scale_reg   <= cfg_data;
                CFG_BINS_IN_USE: bins_in_use_reg <= cfg_data[NBINS_W-1:0];
                CFG_WEIGHTED:    weighted_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Bin lookup: integer part of the Q32.32 product, checked against bins in use
    always_comb
    begin
        look_idx = prod_reg[63:32];
        n_used   = (bins_in_use_reg > NBINS_W'(BINS)) ? NBINS_W'(BINS) : bins_in_use_reg;
        look_hit = (op_reg == OP_SAMPLE)
                   && !(diff_reg[32] && (bin_scale_reg != 32'd0))
                   && (look_idx < {{(32-NBINS_W){1'b0}}, n_used});
    end

    // Saturating bin update
    always_comb
    begin
        bin_inc = weighted_reg ? (BIN_WIDTH+1)'(weight_reg) : (BIN_WIDTH+1)'(1);
        bin_sum = $signed({rdata_reg[BIN_WIDTH-1], rdata_reg}) + bin_inc;
        if (bin_sum > BIN_MAX)
            bin_new = BIN_MAX[BIN_WIDTH-1:0];
        else if (bin_sum < BIN_MIN)
            bin_new = BIN_MIN[BIN_WIDTH-1:0];
        else
            bin_new = bin_sum[BIN_WIDTH-1:0];
        count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = (op_t'(in_data.operation) == OP_CLEAR) ? ST_CLEAR : ST_MUL;
            end
            ST_MUL:   state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_RMW;
            ST_RMW:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = clear_emit_reg ? ST_CEMIT : ST_IDLE;
            end
            ST_CEMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Controller outputs: memory ports, result load, count update
    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        mem_re     = 1'b0;
        mem_raddr  = look_idx[BIN_AW-1:0];
        mem_we     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = bin_new;
        load_out   = 1'b0;
        out_load   = '0;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (op_t'(in_data.operation) == OP_CLEAR))
                    count_next = '0;
            end
            ST_LOOK:
            begin
                mem_re = 1'b1;
                if (op_reg == OP_READ)
                    mem_raddr = rd_idx_reg;
            end
            ST_RMW:
            begin
                load_out              = out_free;
                out_load.binned_total = count_reg;
                if (hit_reg)
                begin
                    mem_we                = out_free;
                    out_load.bin_value    = bin_new;
                    out_load.binned_total = count_inc;
                    out_load.accepted     = 1'b1;
                    out_load.sample_bin   = addr_reg;
                    if (out_free)
                        count_next = count_inc;
                end
                else if (op_reg == OP_READ)
                begin
                    out_load.bin_value = rdata_reg;
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_ptr_reg;
                mem_wdata = '0;
            end
            ST_CEMIT:
            begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_ptr_reg    <= '0;
            clear_emit_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == ST_CLEAR)
                clr_ptr_reg <= clr_ptr_reg + BIN_AW'(1);
            if (in_xfer && (op_t'(in_data.operation) == OP_CLEAR))
                clear_emit_reg <= 1'b1;
            else if ((state_reg == ST_CEMIT) && out_free)
                clear_emit_reg <= 1'b0;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Item datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg     <= op_t'(in_data.operation);
            diff_reg   <= {in_data.sample[31], in_data.sample}
                          - {range_low_reg[31], range_low_reg};
            weight_reg <= in_data.weight;
            rd_idx_reg <= in_data.read_index;
        end
        if (state_reg == ST_MUL)
            prod_reg <= diff_reg[32] ? 64'd0 : (64'(diff_reg[31:0]) * 64'(bin_scale_reg));
        if (state_reg == ST_LOOK)
        begin
            addr_reg <= look_idx[BIN_AW-1:0];
            hit_reg  <= look_hit;
        end
        if (load_out)
            out_data_reg <= out_load;
    end

    // Bin memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= bin_mem[mem_raddr];
    end

`ifndef SYNTH
    // Sweep writes zero to the bin under the clear pointer
    a_sweep_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (mem_we && (mem_wdata == '0) && (mem_waddr == clr_ptr_reg)))
        else $error("clear sweep does not write zero");

    // A result appears only from the update step or after a clear sweep
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RMW || $past(state_reg) == ST_CEMIT))
        else $error("result loaded from unexpected state");

    // Count only steps up by one or returns to zero
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> (count_reg == '0 || count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("binned count jumped");

    // An accepted sample lies inside the bins in use
    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.accepted)
            |-> ({1'b0, out_data_reg.sample_bin} < bins_in_use_reg))
        else $error("accepted sample outside bins in use");

    // Memory is never written while an item is taken
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> !mem_we)
        else $error("memory write during input transfer");
`endif

endmodule
